// ===== sv/aes_cbc_pkg.sv =====
// Package for the AES-128 CBC encryptor: payload types, register indexes,
// S-box and GF(2^8) helpers. Used by aes128_cbc_encrypt.
package aes_cbc_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned BlockBytes = 16;
  localparam logic ModeCbc = 1'b0;
  localparam int unsigned CfgAddrW = 6;

  typedef enum logic [2:0] {
    REG_KEY_HIGH = 3'd0,
    REG_KEY_LOW  = 3'd1,
    REG_IV_HIGH  = 3'd2,
    REG_IV_LOW   = 3'd3,
    REG_MODE     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic        first_block;
    logic        last_block;
  } in_payload_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic        last_out;
    logic        mode_error;
  } out_payload_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
      8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
      8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
      8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
      8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
      8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
      8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
      8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
      8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
      8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
      8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
      8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
      8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
      8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
      8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
      8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
      8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // One cipher round on a state whose byte 0 is the most significant.
  function automatic logic [127:0] aes_round(input logic [127:0] s,
                                             input logic [127:0] rk,
                                             input logic final_rnd);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) b[i] = s[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int k = 0; k < 4; k++) t[c*4 + k] = sbox(b[((c + k) % 4)*4 + k]);
    if (!final_rnd) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
    return r ^ rk;
  endfunction

  // Next round key from the current one and the round constant.
  function automatic logic [127:0] next_key(input logic [127:0] k,
                                            input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, tw;
    tw = sub_word({k[23:0], k[31:24]}) ^ {rc, 24'h0};
    w0 = k[127:96] ^ tw;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

// ===== sv/aes128_cbc_encrypt.sv =====
// AES-128 CBC encryptor top level: APB register file, round sequencer and
// one shared round unit with on-the-fly key schedule. Depends on aes_cbc_pkg.
//
// Usage: write key, IV and mode over the cfg_ APB port while idle. Send one
// plaintext request per block on in_ (valid/ready); set first_block on the
// first block of each message to chain from the IV. Each request yields one
// ciphertext request on out_.
// Sequencing: the accepting cycle loads the state, the round state then runs
// the ten rounds, and the result is offered from ST_OUT; a mode
// error result is offered in the cycle after acceptance. The single shared round
// unit is used once per round, so a new block is taken only after the
// previous result has been handed off on out_.
// A receiver stall holds the result in the output register and the block
// stays busy until the result is taken; in_ready is low meanwhile.
// Reset clears the configuration registers, the chain value and the handshake state.
// The round key is derived per round from a stored copy of the cipher key,
// refreshed whenever a first block arrives.
module aes128_cbc_encrypt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  aes_cbc_pkg::in_payload_t  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output aes_cbc_pkg::out_payload_t out_data,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [aes_cbc_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [63:0]               cfg_pwdata,
  output logic [63:0]               cfg_prdata,
  output logic                      cfg_pready
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_OUT   = 3'b100
  } state_t;

  logic [127:0] key_r, iv_r, ckey_r, rkey_r, chain_r, st_r;
  logic [127:0] key_nxt, iv_nxt, ckey_nxt, rkey_nxt, chain_nxt, st_nxt;
  logic         mode_r, mode_nxt;
  state_t       state_r, state_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic [7:0]   rc_r, rc_nxt;
  logic         last_r, last_nxt, err_r, err_nxt;
  logic [127:0] rk_next, rnd_out;
  logic [2:0]   reg_sel;
  logic         wr_en;
  logic [127:0] chain_in;

  assign cfg_pready = 1'b1;
  assign reg_sel = cfg_paddr[5:3];
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  // Register readback.
  always_comb begin
    case (reg_sel)
      aes_cbc_pkg::REG_KEY_HIGH: cfg_prdata = key_r[127:64];
      aes_cbc_pkg::REG_KEY_LOW:  cfg_prdata = key_r[63:0];
      aes_cbc_pkg::REG_IV_HIGH:  cfg_prdata = iv_r[127:64];
      aes_cbc_pkg::REG_IV_LOW:   cfg_prdata = iv_r[63:0];
      aes_cbc_pkg::REG_MODE:     cfg_prdata = {63'h0, mode_r};
      default:                   cfg_prdata = 64'h0;
    endcase
  end

  // Shared round unit and key schedule step.
  assign rk_next = aes_cbc_pkg::next_key(rkey_r, rc_r);
  assign rnd_out = aes_cbc_pkg::aes_round(st_r, rk_next, rnd_r == 4'd10);

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data.cipher_high = err_r ? 64'h0 : st_r[127:64];
  assign out_data.cipher_low  = err_r ? 64'h0 : st_r[63:0];
  assign out_data.last_out = last_r;
  assign out_data.mode_error = err_r;

  always_comb begin
    key_nxt = key_r;
    iv_nxt = iv_r;
    mode_nxt = mode_r;
    ckey_nxt = ckey_r;
    rkey_nxt = rkey_r;
    chain_nxt = chain_r;
    st_nxt = st_r;
    state_nxt = state_r;
    rnd_nxt = rnd_r;
    rc_nxt = rc_r;
    last_nxt = last_r;
    err_nxt = err_r;
    chain_in = in_data.first_block ? iv_r : chain_r;
    // Configuration writes.
    if (wr_en) begin
      case (reg_sel)
        aes_cbc_pkg::REG_KEY_HIGH: key_nxt[127:64] = cfg_pwdata;
        aes_cbc_pkg::REG_KEY_LOW:  key_nxt[63:0] = cfg_pwdata;
        aes_cbc_pkg::REG_IV_HIGH:  iv_nxt[127:64] = cfg_pwdata;
        aes_cbc_pkg::REG_IV_LOW:   iv_nxt[63:0] = cfg_pwdata;
        aes_cbc_pkg::REG_MODE:     mode_nxt = cfg_pwdata[0];
        default: ;
      endcase
    end
    // Round sequencer.
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          last_nxt = in_data.last_block;
          err_nxt = (mode_r != aes_cbc_pkg::ModeCbc);
          if (in_data.first_block) ckey_nxt = key_r;
          rkey_nxt = in_data.first_block ? key_r : ckey_r;
          st_nxt = {in_data.plain_high, in_data.plain_low} ^ chain_in ^
                   (in_data.first_block ? key_r : ckey_r);
          rnd_nxt = 4'd1;
          rc_nxt = 8'h01;
          state_nxt = err_nxt ? ST_OUT : ST_ROUND;
        end
      end
      ST_ROUND: begin
        st_nxt = rnd_out;
        rkey_nxt = rk_next;
        rc_nxt = aes_cbc_pkg::xtime(rc_r);
        rnd_nxt = rnd_r + 4'd1;
        if (rnd_r == 4'd10) begin
          chain_nxt = rnd_out;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      key_r <= '0;
      iv_r <= '0;
      mode_r <= 1'b0;
      chain_r <= '0;
      rnd_r <= 4'd0;
      err_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      key_r <= key_nxt;
      iv_r <= iv_nxt;
      mode_r <= mode_nxt;
      chain_r <= chain_nxt;
      rnd_r <= rnd_nxt;
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ckey_r <= ckey_nxt;
    rkey_r <= rkey_nxt;
    st_r <= st_nxt;
    rc_r <= rc_nxt;
    last_r <= last_nxt;
  end

  // The chain only moves at the end of the last round.
  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_ROUND || rnd_r != 4'd10) |=> $stable(chain_r))
    else $error("chain value changed outside the final round");
  // Error results never run rounds.
  a_err_norounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> !err_r)
    else $error("round running on an error request");
  // After the final round the result is offered.
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == 4'd10) |=> (state_r == ST_OUT))
    else $error("missing result after final round");
  // Round counter stays in range while rounds run.
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (rnd_r >= 4'd1 && rnd_r <= 4'd10))
    else $error("round counter out of range");

endmodule
